// File: rtl/acbm_pkg.sv
`default_nettype none

package acbm_pkg;

    localparam int unsigned AddrW   = 64;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned StatusW = 3;

    // Input item selector.
    localparam logic IN_TICK = 1'b0;
    localparam logic IN_RESP = 1'b1;

    // Done status codes.
    localparam logic [StatusW-1:0] ST_OK      = 3'd0;
    localparam logic [StatusW-1:0] ST_INVALID = 3'd7;

    typedef enum logic [1:0] {
        KIND_CHECK = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LDI   = 3'd1,
        OP_LOAD  = 3'd2,
        OP_STORE = 3'd3,
        OP_JUMP  = 3'd4,
        OP_INC   = 3'd5,
        OP_DEC   = 3'd6,
        OP_HALT  = 3'd7
    } t_opcode;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_CHECK = 7'b0000010,
        PH_OPC   = 7'b0000100,
        PH_IMM   = 7'b0001000,
        PH_ADDR  = 7'b0010000,
        PH_LOAD  = 7'b0100000,
        PH_STORE = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [AddrW-1:0]   bus_address;
        logic [ByteW-1:0]   write_byte;
        logic [StatusW-1:0] done_status;
        logic [ByteW-1:0]   accumulator;
        logic               halted;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/acbm_core.sv
`default_nettype none

module acbm_core
    import acbm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [AddrW-1:0]   i_cfg_wr_data,
    input  wire logic               i_step,
    input  wire logic               i_op,
    input  wire logic [StatusW-1:0] i_status,
    input  wire logic [ByteW-1:0]   i_data,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    localparam logic [AddrW-1:0] PcMax = '1;

    t_phase           r_phase, n_phase;
    logic [AddrW-1:0] r_pc, n_pc;
    logic [ByteW-1:0] r_acc, n_acc;
    logic             r_halt, n_halt;
    t_opcode          r_instr, n_instr;
    logic [AddrW-1:0] r_gather, n_gather;
    logic [2:0]       r_byte_idx, n_byte_idx;

    logic [AddrW-1:0] pc_inc;
    logic [AddrW-1:0] gather_new;
    logic             res_valid;
    t_kind            res_kind;
    logic [AddrW-1:0] res_addr;
    logic [ByteW-1:0] res_wb;
    logic [StatusW-1:0] res_st;

    assign pc_inc = r_pc + AddrW'(1);

    always_comb begin
        gather_new = r_gather;
        gather_new[r_byte_idx*ByteW +: ByteW] = r_gather[r_byte_idx*ByteW +: ByteW] | i_data;
    end

    always_comb begin
        n_phase    = r_phase;
        n_pc       = r_pc;
        n_acc      = r_acc;
        n_halt     = r_halt;
        n_instr    = r_instr;
        n_gather   = r_gather;
        n_byte_idx = r_byte_idx;
        res_valid  = 1'b0;
        res_kind   = KIND_DONE;
        res_addr   = r_pc;
        res_wb     = '0;
        res_st     = ST_OK;

        if (i_op == IN_TICK) begin
            if (r_phase == PH_IDLE) begin
                res_valid = 1'b1;
                if (!r_halt) begin
                    n_phase  = PH_CHECK;
                    res_kind = KIND_CHECK;
                end
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_CHECK: begin
                    res_valid = 1'b1;
                    n_phase   = PH_IDLE;
                    if (i_status != ST_OK) begin
                        res_st = i_status;
                    end else if (r_pc == PcMax) begin
                        n_halt = 1'b1;
                        res_st = ST_INVALID;
                    end else begin
                        n_phase  = PH_OPC;
                        res_kind = KIND_READ;
                    end
                end
                PH_OPC: begin
                    res_valid = 1'b1;
                    n_phase   = PH_IDLE;
                    if (i_status != ST_OK) begin
                        n_halt = 1'b1;
                        res_st = i_status;
                    end else begin
                        n_pc     = pc_inc;
                        res_addr = pc_inc;
                        if (i_data[ByteW-1:3] != '0) begin
                            n_halt = 1'b1;
                            res_st = ST_INVALID;
                        end else begin
                            n_instr = t_opcode'(i_data[2:0]);
                            case (t_opcode'(i_data[2:0]))
                                OP_LDI, OP_LOAD, OP_STORE, OP_JUMP: begin
                                    n_gather   = '0;
                                    n_byte_idx = '0;
                                    // Multi-byte ops read next byte unless pc_inc==PcMax.
                                    if (pc_inc == PcMax) begin
                                        n_halt = 1'b1;
                                        res_st = ST_INVALID;
                                    end else begin
                                        n_phase  = (i_data[2:0] == OP_LDI) ? PH_IMM : PH_ADDR;
                                        res_kind = KIND_READ;
                                    end
                                end
                                OP_INC:  n_acc  = r_acc + ByteW'(1);
                                OP_DEC:  n_acc  = r_acc - ByteW'(1);
                                OP_HALT: n_halt = 1'b1;
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                PH_IMM: begin
                    res_valid = 1'b1;
                    n_phase   = PH_IDLE;
                    if (i_status != ST_OK) begin
                        n_halt = 1'b1;
                        res_st = i_status;
                    end else begin
                        n_acc    = i_data;
                        n_pc     = pc_inc;
                        res_addr = pc_inc;
                    end
                end
                PH_ADDR: begin
                    res_valid = 1'b1;
                    n_phase   = PH_IDLE;
                    if (i_status != ST_OK) begin
                        n_halt = 1'b1;
                        res_st = i_status;
                    end else begin
                        n_gather = gather_new;
                        n_pc     = pc_inc;
                        res_addr = pc_inc;
                        if (r_byte_idx != 3'd7) begin
                            n_byte_idx = r_byte_idx + 3'd1;
                            if (pc_inc == PcMax) begin
                                n_halt = 1'b1;
                                res_st = ST_INVALID;
                            end else begin
                                n_phase  = PH_ADDR;
                                res_kind = KIND_READ;
                            end
                        end else if (r_instr == OP_LOAD) begin
                            n_phase  = PH_LOAD;
                            res_kind = KIND_READ;
                            res_addr = gather_new;
                        end else if (r_instr == OP_STORE) begin
                            n_phase  = PH_STORE;
                            res_kind = KIND_WRITE;
                            res_addr = gather_new;
                            res_wb   = r_acc;
                        end else begin
                            // Jump: the done item reports the new pc.
                            n_pc     = gather_new;
                            res_addr = gather_new;
                        end
                    end
                end
                PH_LOAD: begin
                    res_valid = 1'b1;
                    n_phase   = PH_IDLE;
                    if (i_status != ST_OK) begin
                        n_halt = 1'b1;
                        res_st = i_status;
                    end else begin
                        n_acc = i_data;
                    end
                end
                PH_STORE: begin
                    res_valid = 1'b1;
                    n_phase   = PH_IDLE;
                    if (i_status != ST_OK) begin
                        n_halt = 1'b1;
                        res_st = i_status;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_acc      <= '0;
            r_halt     <= 1'b0;
            r_phase    <= PH_IDLE;
            r_instr    <= OP_NOP;
            r_gather   <= '0;
            r_byte_idx <= '0;
        end else if (i_cfg_wr_en) begin
            r_pc       <= i_cfg_wr_data;
            r_acc      <= '0;
            r_halt     <= 1'b0;
            r_phase    <= PH_IDLE;
            r_instr    <= OP_NOP;
            r_gather   <= '0;
            r_byte_idx <= '0;
        end else if (i_step) begin
            r_pc       <= n_pc;
            r_acc      <= n_acc;
            r_halt     <= n_halt;
            r_phase    <= n_phase;
            r_instr    <= n_instr;
            r_gather   <= n_gather;
            r_byte_idx <= n_byte_idx;
        end
    end

    assign o_res_valid = i_step && res_valid;
    assign o_res = '{kind: res_kind, bus_address: res_addr, write_byte: res_wb,
                     done_status: res_st, accumulator: n_acc, halted: n_halt};

endmodule

`default_nettype wire

// File: rtl/accumulator_cpu_bus_master_top.sv
// A result item is registered and presented on the master side in the cycle after its input
// item is accepted. Throughput: one item per cycle while m_axis_tready does not stall output;
// the single output register is refilled in the cycle it drains. Items that cause no result
// (stray tick or response) are consumed without output. Reset (synchronous, active low)
// clears pc, accumulator and halt flag to zero and empties the output register.
`default_nettype none

module accumulator_cpu_bus_master_top
    import acbm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [AddrW-1:0]   i_cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [15:0]        s_axis_tdata,   // resp_status[2:0], resp_data[10:3]
    input  wire logic [0:0]         s_axis_tuser,   // opcode[0]
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [87:0]             m_axis_tdata,   // bus_address[63:0], write_byte[71:64],
                                                    // done_status[74:72],
                                                    // accumulator_out[82:75], halted_out[83]
    output logic [1:0]              m_axis_tuser    // kind[1:0]
);

    logic    step;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    acbm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_op          (s_axis_tuser[0]),
        .i_status      (s_axis_tdata[2:0]),
        .i_data        (s_axis_tdata[10:3]),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {4'b0000, r_out.halted, r_out.accumulator, r_out.done_status,
                            r_out.write_byte, r_out.bus_address};

endmodule

`default_nettype wire
